### src/gbba_pkg.sv
// ----------------------------------------------------------------------------
// gbba_pkg
// Shared constants, codes and control types of the grouped bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gbba_pkg;

    localparam int GROUP_BLOCKS    = 1024;
    localparam int MAX_GROUPS      = 64;
    localparam int WORD_BITS       = 64;
    localparam int WORDS_PER_GROUP = GROUP_BLOCKS / WORD_BITS;
    localparam int MAP_WORDS       = MAX_GROUPS * WORDS_PER_GROUP;

    localparam int GROUP_W  = $clog2(MAX_GROUPS);
    localparam int NGROUP_W = $clog2(MAX_GROUPS + 1);
    localparam int WIDX_W   = $clog2(WORDS_PER_GROUP);
    localparam int BIT_W    = $clog2(WORD_BITS);
    localparam int ADDR_W   = $clog2(MAP_WORDS);
    localparam int OFF_W    = $clog2(GROUP_BLOCKS);
    localparam int CNT_W    = $clog2(GROUP_BLOCKS + 1);
    localparam int TOTAL_W  = 17;
    localparam int BLOCK_W  = 32;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 2;
    localparam int GCFG_W   = 7;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NO_SPACE      = 2'd1,
        ST_OUT_OF_BOUNDS = 2'd2,
        ST_NOT_ALLOCATED = 2'd3
    } status_t;

    typedef enum logic [IDX_W-1:0] {
        REG_GROUPS      = 2'd0,
        REG_FIRST_BLOCK = 2'd1,
        REG_DATA_END    = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        CSRC_SCAN   = 2'd0,
        CSRC_FREE   = 2'd1,
        CSRC_RELOAD = 2'd2
    } cnt_src_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ASTART,
        S_HMOD,
        S_GRD,
        S_GCHK,
        S_WRD,
        S_WCHK,
        S_FBND,
        S_FCHK,
        S_RSTART,
        S_RRD,
        S_RACC,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     clear_wr;
        logic     hmod_sub;
        logic     cnt_rd;
        cnt_src_t cnt_src;
        logic     grp_next;
        logic     word_rd;
        logic     word_next;
        logic     alloc_commit;
        logic     free_rd;
        logic     free_commit;
        logic     set_fail;
        status_t  fail_code;
        logic     rld_start;
        logic     rld_acc;
        logic     rld_done;
        logic     load_out;
    } cmd_t;

    typedef struct packed {
        logic is_free;
        logic total_zero;
        logic hint_ge_n;
        logic visit_done;
        logic cnt_zero;
        logic word_full;
        logic word_last;
        logic free_oob;
        logic bit_set;
        logic clear_last;
        logic rld_end;
        logic reload_pend;
    } stat_t;

    // index of the lowest clear bit of a bitmap word
    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!w[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### src/gbba_if.sv
// ----------------------------------------------------------------------------
// gbba_req_if / gbba_rsp_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbba_req_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic [gbba_pkg::BLOCK_W-1:0]        block_to_free;

    modport source (output valid, output operation, output block_to_free, input ready);
    modport sink   (input valid, input operation, input block_to_free, output ready);
endinterface

interface gbba_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic [gbba_pkg::BLOCK_W-1:0]        allocated_block;
    logic [gbba_pkg::TOTAL_W-1:0]        free_blocks_left;
    logic [31:0]                         alloc_total;
    logic [31:0]                         release_total;

    modport source (output valid, output status, output allocated_block,
                    output free_blocks_left, output alloc_total, output release_total,
                    input ready);
    modport sink   (input valid, input status, input allocated_block,
                    input free_blocks_left, input alloc_total, input release_total,
                    output ready);
endinterface

`default_nettype wire

### src/grouped_bitmap_block_allocator.sv
// ----------------------------------------------------------------------------
// grouped_bitmap_block_allocator
// Block allocator over per-group free bitmaps with a rotating group hint.
// ----------------------------------------------------------------------------
// Usage:
//   req  : valid/ready word carrying operation (0 allocate, 1 free) and
//          block_to_free. rsp : one word per request with status, block,
//          free count and the two wrapping operation counters.
//   cfg  : cfg_write/cfg_index/cfg_data, written while the block is idle.
//          Writing groups_in_use reloads the free count; req.ready stays
//          low until the reload has finished.
//   Sequence: a free checks the bounds, then reads its bitmap word and
//   group count and commits (an out-of-bounds free fails at the bounds
//   check); an allocate with no space fails at once. An allocate otherwise
//   reduces the hint, skips empty groups and reads a group's 64-bit bitmap
//   words one by one from the single-port memory. One request is in flight.
//   Reset: a clearing pass writes all 1024 bitmap words, one per cycle;
//   req.ready stays low until the pass is done.
//   Stall: the result sits in an output register; the next request is
//   accepted and worked on, then waits if that register is still full.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_bitmap_block_allocator
(
    input  wire                              clk,
    input  wire                              rst_n,
    gbba_req_if.sink                         req,
    gbba_rsp_if.source                       rsp,
    input  wire                              cfg_write,
    input  wire  [gbba_pkg::IDX_W-1:0]       cfg_index,
    input  wire  [gbba_pkg::CFG_W-1:0]       cfg_data
);

    gbba_pkg::cmd_t  cmd;
    gbba_pkg::stat_t stat;
    logic            in_ready;
    logic            out_valid;

    gbba_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gbba_datapath u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_operation      (req.operation),
        .in_block          (req.block_to_free),
        .cmd               (cmd),
        .stat              (stat),
        .out_status        (rsp.status),
        .out_block         (rsp.allocated_block),
        .out_free_left     (rsp.free_blocks_left),
        .out_alloc_total   (rsp.alloc_total),
        .out_release_total (rsp.release_total)
    );

    assign req.ready = in_ready;
    assign rsp.valid = out_valid;

endmodule

`default_nettype wire

### src/gbba_ctrl.sv
// ----------------------------------------------------------------------------
// gbba_ctrl
// Sequencer: clearing pass, allocate scan, free check, count reload.
// ----------------------------------------------------------------------------
`default_nettype none

module gbba_ctrl
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  gbba_pkg::stat_t      stat,
    output gbba_pkg::cmd_t       cmd
);

    gbba_pkg::state_t state_reg, state_next;
    logic             out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gbba_pkg::S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == gbba_pkg::S_IDLE) && !stat.reload_pend;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.cnt_src    = gbba_pkg::CSRC_SCAN;
        cmd.fail_code  = gbba_pkg::ST_OK;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            gbba_pkg::S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = gbba_pkg::S_IDLE;
                end
            end
            gbba_pkg::S_IDLE:
            begin
                if (stat.reload_pend)
                begin
                    state_next = gbba_pkg::S_RSTART;
                end
                else if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = gbba_pkg::S_ASTART;
                end
            end
            gbba_pkg::S_ASTART:
            begin
                if (stat.is_free)
                begin
                    state_next = gbba_pkg::S_FBND;
                end
                else if (stat.total_zero)
                begin
                    cmd.set_fail  = 1'b1;
                    cmd.fail_code = gbba_pkg::ST_NO_SPACE;
                    state_next    = gbba_pkg::S_DONE;
                end
                else
                begin
                    state_next = gbba_pkg::S_HMOD;
                end
            end
            gbba_pkg::S_HMOD:
            begin
                // reduce the hint below the group count
                if (stat.hint_ge_n)
                begin
                    cmd.hmod_sub = 1'b1;
                end
                else
                begin
                    state_next = gbba_pkg::S_GRD;
                end
            end
            gbba_pkg::S_GRD:
            begin
                if (stat.visit_done)
                begin
                    cmd.set_fail  = 1'b1;
                    cmd.fail_code = gbba_pkg::ST_NO_SPACE;
                    state_next    = gbba_pkg::S_DONE;
                end
                else
                begin
                    cmd.cnt_rd = 1'b1;
                    state_next = gbba_pkg::S_GCHK;
                end
            end
            gbba_pkg::S_GCHK:
            begin
                if (stat.cnt_zero)
                begin
                    cmd.grp_next = 1'b1;
                    state_next   = gbba_pkg::S_GRD;
                end
                else
                begin
                    state_next = gbba_pkg::S_WRD;
                end
            end
            gbba_pkg::S_WRD:
            begin
                cmd.word_rd = 1'b1;
                state_next  = gbba_pkg::S_WCHK;
            end
            gbba_pkg::S_WCHK:
            begin
                if (!stat.word_full)
                begin
                    cmd.alloc_commit = 1'b1;
                    state_next       = gbba_pkg::S_DONE;
                end
                else if (stat.word_last)
                begin
                    cmd.grp_next = 1'b1;
                    state_next   = gbba_pkg::S_GRD;
                end
                else
                begin
                    cmd.word_next = 1'b1;
                    state_next    = gbba_pkg::S_WRD;
                end
            end
            gbba_pkg::S_FBND:
            begin
                if (stat.free_oob)
                begin
                    cmd.set_fail  = 1'b1;
                    cmd.fail_code = gbba_pkg::ST_OUT_OF_BOUNDS;
                    state_next    = gbba_pkg::S_DONE;
                end
                else
                begin
                    cmd.free_rd = 1'b1;
                    cmd.cnt_rd  = 1'b1;
                    cmd.cnt_src = gbba_pkg::CSRC_FREE;
                    state_next  = gbba_pkg::S_FCHK;
                end
            end
            gbba_pkg::S_FCHK:
            begin
                if (stat.bit_set)
                begin
                    cmd.free_commit = 1'b1;
                end
                else
                begin
                    cmd.set_fail  = 1'b1;
                    cmd.fail_code = gbba_pkg::ST_NOT_ALLOCATED;
                end
                state_next = gbba_pkg::S_DONE;
            end
            gbba_pkg::S_RSTART:
            begin
                cmd.rld_start = 1'b1;
                state_next    = gbba_pkg::S_RRD;
            end
            gbba_pkg::S_RRD:
            begin
                if (stat.rld_end)
                begin
                    cmd.rld_done = 1'b1;
                    state_next   = gbba_pkg::S_IDLE;
                end
                else
                begin
                    cmd.cnt_rd  = 1'b1;
                    cmd.cnt_src = gbba_pkg::CSRC_RELOAD;
                    state_next  = gbba_pkg::S_RACC;
                end
            end
            gbba_pkg::S_RACC:
            begin
                cmd.rld_acc = 1'b1;
                state_next  = gbba_pkg::S_RRD;
            end
            gbba_pkg::S_DONE:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = gbba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = gbba_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/gbba_datapath.sv
// ----------------------------------------------------------------------------
// gbba_datapath
// Bitmap and group count memories, configuration, counters and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module gbba_datapath
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_write,
    input  wire  [gbba_pkg::IDX_W-1:0]           cfg_index,
    input  wire  [gbba_pkg::CFG_W-1:0]           cfg_data,
    input  wire                                  in_operation,
    input  wire  [gbba_pkg::BLOCK_W-1:0]         in_block,
    input  gbba_pkg::cmd_t                       cmd,
    output gbba_pkg::stat_t                      stat,
    output logic [1:0]                           out_status,
    output logic [gbba_pkg::BLOCK_W-1:0]         out_block,
    output logic [gbba_pkg::TOTAL_W-1:0]         out_free_left,
    output logic [31:0]                          out_alloc_total,
    output logic [31:0]                          out_release_total
);

    localparam int GW  = gbba_pkg::GROUP_W;
    localparam int NW  = gbba_pkg::NGROUP_W;
    localparam int WW  = gbba_pkg::WIDX_W;
    localparam int BW  = gbba_pkg::BIT_W;
    localparam int AW  = gbba_pkg::ADDR_W;
    localparam int CW  = gbba_pkg::CNT_W;
    localparam int TW  = gbba_pkg::TOTAL_W;
    localparam int LW  = gbba_pkg::BLOCK_W;
    localparam int DW  = gbba_pkg::WORD_BITS;
    localparam int OW  = gbba_pkg::OFF_W;
    localparam int TOTAL_RESET = gbba_pkg::MAX_GROUPS * gbba_pkg::GROUP_BLOCKS;

    // configuration and control state
    logic [NW-1:0] groups_reg;
    logic [LW-1:0] first_block_reg, data_end_reg;
    logic          reload_pend_reg;
    logic [GW-1:0] hint_reg, cur_reg;
    logic [NW-1:0] visit_reg, ridx_reg;
    logic [WW-1:0] widx_reg;
    logic [AW-1:0] clear_addr_reg;
    logic [TW-1:0] total_reg, sum_reg;
    logic [31:0]   alloc_cnt_reg, rel_cnt_reg;
    logic [gbba_pkg::MAX_GROUPS-1:0] cvalid_reg;

    // payload
    logic          op_reg;
    logic [LW-1:0] blk_reg;
    logic [1:0]    pend_status_reg;
    logic [LW-1:0] pend_block_reg;
    logic [DW-1:0] word_rd_reg;
    logic [CW-1:0] cnt_rd_reg;
    logic          cnt_rdv_reg;
    logic [1:0]    out_status_reg;
    logic [LW-1:0] out_block_reg;
    logic [TW-1:0] out_free_reg;
    logic [31:0]   out_alloc_reg, out_rel_reg;

    logic [DW-1:0] bitmap_mem [gbba_pkg::MAP_WORDS];
    logic [CW-1:0] count_mem  [gbba_pkg::MAX_GROUPS];

    // datapath decode
    logic [LW-1:0] off;
    logic [GW-1:0] fgroup;
    logic [BW-1:0] fbit, abit;
    logic [CW-1:0] cnt_val;
    logic [NW-1:0] cur_inc;
    logic [AW-1:0] mem_addr;
    logic [DW-1:0] mem_wdata;
    logic          mem_we, mem_re;
    logic [GW-1:0] crd_addr, cwr_addr;
    logic [CW-1:0] cwr_data;
    logic          cnt_we;
    logic [NW-1:0] gcfg;

    assign off     = blk_reg - first_block_reg;
    assign fgroup  = off[OW+GW-1:OW];
    assign fbit    = off[BW-1:0];
    assign abit    = gbba_pkg::lowest_zero(word_rd_reg);
    assign cnt_val = cnt_rdv_reg ? cnt_rd_reg : CW'(gbba_pkg::GROUP_BLOCKS);
    assign cur_inc = NW'(cur_reg) + NW'(1);
    assign gcfg    = (cfg_data[NW-1:0] > NW'(gbba_pkg::MAX_GROUPS))
                     ? NW'(gbba_pkg::MAX_GROUPS) : cfg_data[NW-1:0];

    assign stat.is_free     = op_reg;
    assign stat.total_zero  = (total_reg == '0) || (groups_reg == '0);
    assign stat.hint_ge_n   = NW'(cur_reg) >= groups_reg;
    assign stat.visit_done  = visit_reg == groups_reg;
    assign stat.cnt_zero    = cnt_val == '0;
    assign stat.word_full   = &word_rd_reg;
    assign stat.word_last   = widx_reg == WW'(gbba_pkg::WORDS_PER_GROUP - 1);
    assign stat.free_oob    = (blk_reg < first_block_reg) || (blk_reg >= data_end_reg)
                              || (off[LW-1:OW] >= (LW-OW)'(groups_reg));
    assign stat.bit_set     = word_rd_reg[fbit];
    assign stat.clear_last  = clear_addr_reg == AW'(gbba_pkg::MAP_WORDS - 1);
    assign stat.rld_end     = ridx_reg == groups_reg;
    assign stat.reload_pend = reload_pend_reg;

    // bitmap port select
    always_comb
    begin
        mem_addr  = {cur_reg, widx_reg};
        mem_wdata = word_rd_reg;
        mem_we    = 1'b0;
        mem_re    = cmd.word_rd || cmd.free_rd;
        if (cmd.clear_wr)
        begin
            mem_addr  = clear_addr_reg;
            mem_wdata = '0;
            mem_we    = 1'b1;
        end
        else if (cmd.free_rd || cmd.free_commit)
        begin
            mem_addr = off[AW+BW-1:BW];
            if (cmd.free_commit)
            begin
                mem_wdata = word_rd_reg & ~(DW'(1) << fbit);
                mem_we    = 1'b1;
            end
        end
        else if (cmd.alloc_commit)
        begin
            mem_wdata = word_rd_reg | (DW'(1) << abit);
            mem_we    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            word_rd_reg <= bitmap_mem[mem_addr];
        end
    end

    // group count port select
    always_comb
    begin
        case (cmd.cnt_src)
            gbba_pkg::CSRC_FREE:   crd_addr = fgroup;
            gbba_pkg::CSRC_RELOAD: crd_addr = ridx_reg[GW-1:0];
            default:               crd_addr = cur_reg;
        endcase
        cnt_we   = cmd.alloc_commit || cmd.free_commit;
        cwr_addr = cmd.free_commit ? fgroup : cur_reg;
        cwr_data = cmd.free_commit ? cnt_val + CW'(1) : cnt_val - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            count_mem[cwr_addr] <= cwr_data;
        end
        if (cmd.cnt_rd)
        begin
            cnt_rd_reg  <= count_mem[crd_addr];
            cnt_rdv_reg <= cvalid_reg[crd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cvalid_reg <= '0;
        end
        else if (cnt_we)
        begin
            cvalid_reg[cwr_addr] <= 1'b1;
        end
    end

    // configuration and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            groups_reg      <= NW'(gbba_pkg::MAX_GROUPS);
            first_block_reg <= '0;
            data_end_reg    <= LW'(65536);
            reload_pend_reg <= 1'b0;
            hint_reg        <= '0;
            cur_reg         <= '0;
            visit_reg       <= '0;
            ridx_reg        <= '0;
            widx_reg        <= '0;
            clear_addr_reg  <= '0;
            total_reg       <= TW'(TOTAL_RESET);
            sum_reg         <= '0;
            alloc_cnt_reg   <= '0;
            rel_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (reg_idx_cast(cfg_index))
                    gbba_pkg::REG_GROUPS:
                    begin
                        groups_reg      <= gcfg;
                        reload_pend_reg <= 1'b1;
                    end
                    gbba_pkg::REG_FIRST_BLOCK: first_block_reg <= cfg_data;
                    gbba_pkg::REG_DATA_END:    data_end_reg    <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            else if (cmd.rld_start)
            begin
                reload_pend_reg <= 1'b0;
            end
            if (cmd.clear_wr)
            begin
                clear_addr_reg <= clear_addr_reg + AW'(1);
            end
            if (cmd.accept)
            begin
                cur_reg   <= hint_reg;
                visit_reg <= '0;
                widx_reg  <= '0;
            end
            if (cmd.hmod_sub)
            begin
                cur_reg <= cur_reg - groups_reg[GW-1:0];
            end
            if (cmd.grp_next)
            begin
                cur_reg   <= (cur_inc == groups_reg) ? '0 : cur_inc[GW-1:0];
                visit_reg <= visit_reg + NW'(1);
                widx_reg  <= '0;
            end
            if (cmd.word_next)
            begin
                widx_reg <= widx_reg + WW'(1);
            end
            if (cmd.alloc_commit)
            begin
                total_reg     <= total_reg - TW'(1);
                hint_reg      <= cur_reg;
                alloc_cnt_reg <= alloc_cnt_reg + 32'd1;
            end
            if (cmd.free_commit)
            begin
                total_reg   <= total_reg + TW'(1);
                rel_cnt_reg <= rel_cnt_reg + 32'd1;
                if (fgroup < hint_reg)
                begin
                    hint_reg <= fgroup;
                end
            end
            if (cmd.rld_start)
            begin
                sum_reg  <= '0;
                ridx_reg <= '0;
            end
            if (cmd.rld_acc)
            begin
                sum_reg  <= sum_reg + TW'(cnt_val);
                ridx_reg <= ridx_reg + NW'(1);
            end
            if (cmd.rld_done)
            begin
                total_reg <= sum_reg;
            end
        end
    end

    function automatic gbba_pkg::reg_idx_t reg_idx_cast(input logic [gbba_pkg::IDX_W-1:0] v);
        return gbba_pkg::reg_idx_t'(v);
    endfunction

    // request word and result
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= in_operation;
            blk_reg <= in_block;
        end
        if (cmd.set_fail)
        begin
            pend_status_reg <= cmd.fail_code;
            pend_block_reg  <= '0;
        end
        if (cmd.alloc_commit)
        begin
            pend_status_reg <= gbba_pkg::ST_OK;
            pend_block_reg  <= first_block_reg + LW'({cur_reg, widx_reg, abit});
        end
        if (cmd.free_commit)
        begin
            pend_status_reg <= gbba_pkg::ST_OK;
            pend_block_reg  <= '0;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= pend_status_reg;
            out_block_reg  <= pend_block_reg;
            out_free_reg   <= total_reg;
            out_alloc_reg  <= alloc_cnt_reg;
            out_rel_reg    <= rel_cnt_reg;
        end
    end

    assign out_status        = out_status_reg;
    assign out_block         = out_block_reg;
    assign out_free_left     = out_free_reg;
    assign out_alloc_total   = out_alloc_reg;
    assign out_release_total = out_rel_reg;

`ifndef SYNTHESIS
    a_total_max: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= TW'(TOTAL_RESET))
        else $error("free total above capacity");
    a_alloc_has_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |-> (cnt_val != '0) && (total_reg != '0))
        else $error("allocate commit from an empty group");
    a_free_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.free_commit |-> word_rd_reg[fbit])
        else $error("free commit of a clear bit");
    a_alloc_total_dec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.alloc_commit |=> total_reg == $past(total_reg) - TW'(1))
        else $error("free total not decremented");
`endif

endmodule

`default_nettype wire
